// ===== hdl/ghrc_pkg.sv =====
// Shared types, constants and CORDIC tables for the goal heading and reach check.
// No dependencies; imported by every module of the block but ghrc_delay.
package ghrc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;
  localparam logic [31:0] RADIUS_RESET = 32'd16384;

  localparam int SC_LAT = CORDIC_STEPS + 1;
  localparam int ROT_LAT = 5;
  localparam int AT_LAT = CORDIC_STEPS + 2;
  localparam int SQ_LAT = 35;
  localparam int HEAD_LAT = SC_LAT + ROT_LAT + AT_LAT;

  localparam int DIFF_W = 33;
  localparam int TRIG_W = 32;
  localparam int ROT_W = 37;
  localparam int DIST_W = 33;

  typedef enum logic [1:0] {
    CFG_ROLL   = 2'd0,
    CFG_PITCH  = 2'd1,
    CFG_YAW    = 2'd2,
    CFG_RADIUS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] imu_roll;
    logic signed [15:0] imu_pitch;
    logic signed [15:0] imu_yaw;
  } in_item_t;

  typedef struct packed {
    logic               reached;
    logic signed [15:0] heading_angle;
    logic [32:0]        goal_distance;
  } out_item_t;

  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/goal_heading_and_reach_check_top.sv =====
// Goal heading and reach check: top level with input stage, alignment and output register.
// Depends on ghrc_pkg, ghrc_delay, ghrc_sincos, ghrc_rot, ghrc_atan and ghrc_sqrt.
//
// Takes one goal/position/IMU sample per clock and returns one result per sample, in order,
// through an input register, 17 sine/cosine CORDIC stages, 5 matrix stages, 18 arctangent
// CORDIC stages and an output register; the distance root (35 stages) runs alongside and is
// delayed to match. The whole pipeline advances together whenever the output register is
// empty or being taken, so a stalled result holds every stage in place. Offsets and radius
// are written via cfg_we/cfg_addr/cfg_data, by the user only while idle; not enforced.
module goal_heading_and_reach_check_top import ghrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam int DIST_DLY = HEAD_LAT - SQ_LAT;

  logic [15:0] roll_offset, pitch_offset, yaw_offset;
  logic [31:0] reach_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_offset  <= '0;
      pitch_offset <= '0;
      yaw_offset   <= '0;
      reach_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ROLL:   roll_offset  <= cfg_data[15:0];
        CFG_PITCH:  pitch_offset <= cfg_data[15:0];
        CFG_YAW:    yaw_offset   <= cfg_data[15:0];
        CFG_RADIUS: reach_radius <= cfg_data;
        default:    reach_radius <= reach_radius;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                     s0_valid;
  logic signed [DIFF_W-1:0] s0_d0, s0_d1, s0_d2;
  logic [15:0]              s0_roll, s0_pitch, s0_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d0    <= {in_data.goal_x[31], in_data.goal_x} - {in_data.pos_x[31], in_data.pos_x};
      s0_d1    <= {in_data.goal_y[31], in_data.goal_y} - {in_data.pos_y[31], in_data.pos_y};
      s0_d2    <= {in_data.goal_z[31], in_data.goal_z} - {in_data.pos_z[31], in_data.pos_z};
      s0_roll  <= in_data.imu_roll + roll_offset;
      s0_pitch <= in_data.imu_pitch + pitch_offset;
      s0_yaw   <= in_data.imu_yaw + yaw_offset;
    end
  end

  logic signed [TRIG_W-1:0] sr, cr, sp, cp, sy, cy;

  ghrc_sincos u_sc_roll (.clk, .en, .ang(s0_roll), .sn(sr), .cs(cr));
  ghrc_sincos u_sc_pitch (.clk, .en, .ang(s0_pitch), .sn(sp), .cs(cp));
  ghrc_sincos u_sc_yaw (.clk, .en, .ang(s0_yaw), .sn(sy), .cs(cy));

  logic [3*DIFF_W-1:0] d_dly;

  ghrc_delay #(.W(3 * DIFF_W), .N(SC_LAT)) u_d_dly (
    .clk, .en,
    .d({s0_d0, s0_d1, s0_d2}),
    .q(d_dly)
  );

  logic signed [ROT_W-1:0] r0, r2, r2_neg;

  ghrc_rot u_rot (
    .clk, .en,
    .sr, .cr, .sp, .cp, .sy, .cy,
    .d0(d_dly[3*DIFF_W-1 -: DIFF_W]),
    .d1(d_dly[2*DIFF_W-1 -: DIFF_W]),
    .d2(d_dly[DIFF_W-1:0]),
    .r0, .r2
  );

  assign r2_neg = -r2;

  logic [15:0] heading;

  ghrc_atan u_atan (.clk, .en, .x(r0), .y(r2_neg), .ang(heading));

  logic [DIST_W-1:0] dist_raw, dist_dly;

  ghrc_sqrt u_sqrt (.clk, .en, .dy(s0_d1), .dz(s0_d2), .root(dist_raw));

  ghrc_delay #(.W(DIST_W), .N(DIST_DLY)) u_dist_dly (
    .clk, .en, .d(dist_raw), .q(dist_dly)
  );

  logic [HEAD_LAT-1:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp        <= {vp[HEAD_LAT-2:0], s0_valid};
      out_valid <= vp[HEAD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.reached       <= {1'b0, reach_radius} > dist_dly;
      out_data.heading_angle <= heading;
      out_data.goal_distance <= dist_dly;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reached_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reached |-> !out_data.goal_distance[DIST_W-1])
    else $error("reached with distance beyond radius range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

// ===== hdl/ghrc_delay.sv =====
// Enabled shift-register delay line for aligning side data with the pipeline.
// Depends on nothing but its parameters.
module ghrc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// ===== hdl/ghrc_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine in Q2.30 of a 16-bit angle.
// Depends on ghrc_pkg for the arctangent table and gain.
module ghrc_sincos import ghrc_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [15:0]              ang,
  output logic signed [TRIG_W-1:0] sn,
  output logic signed [TRIG_W-1:0] cs
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] xs [1:CORDIC_STEPS];
  logic signed [XW-1:0] ys [1:CORDIC_STEPS];
  logic signed [ZW-1:0] zs [1:CORDIC_STEPS];
  logic                 fl [1:CORDIC_STEPS];

  logic                 fold;
  logic [15:0]          ang_f;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [ZW-1:0] z0;

  assign fold  = (ang > 16'h4000) && (ang < 16'hC000);
  assign ang_f = fold ? (ang ^ 16'h8000) : ang;
  assign x0    = XW'(CORDIC_GAIN);
  assign y0    = '0;
  assign z0    = {ang_f[15], ang_f, 16'h0000};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 fi;
    logic signed [ZW-1:0] tab;
    if (i == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
      assign fi = fold;
    end else begin : g_rest
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
      assign fi = fl[i];
    end
    assign tab = {1'b0, atan_entry(i)};
    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fi;
        if (!zi[ZW-1]) begin
          xs[i+1] <= xi - (yi >>> i);
          ys[i+1] <= yi + (xi >>> i);
          zs[i+1] <= zi - tab;
        end else begin
          xs[i+1] <= xi + (yi >>> i);
          ys[i+1] <= yi - (xi >>> i);
          zs[i+1] <= zi + tab;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= TRIG_W'(fl[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS]);
      cs <= TRIG_W'(fl[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS]);
    end
  end

endmodule

// ===== hdl/ghrc_rot.sv =====
// Rotation matrix rows 0 and 2 from sines and cosines, applied to the difference.
// Depends on ghrc_pkg for widths; five register stages.
module ghrc_rot import ghrc_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [TRIG_W-1:0] sr,
  input  logic signed [TRIG_W-1:0] cr,
  input  logic signed [TRIG_W-1:0] sp,
  input  logic signed [TRIG_W-1:0] cp,
  input  logic signed [TRIG_W-1:0] sy,
  input  logic signed [TRIG_W-1:0] cy,
  input  logic signed [DIFF_W-1:0] d0,
  input  logic signed [DIFF_W-1:0] d1,
  input  logic signed [DIFF_W-1:0] d2,
  output logic signed [ROT_W-1:0]  r0,
  output logic signed [ROT_W-1:0]  r2
);

  function automatic logic signed [31:0] clamp30(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd1073741824) r = 32'sd1073741824;
    else if (v < -35'sd1073741824) r = -32'sd1073741824;
    else r = 32'(v);
    return r;
  endfunction

  // stage A
  logic signed [63:0] pa_crcp, pa_srcy, pa_crsp, pa_srsy, pa_sysp, pa_sycp;
  logic signed [32:0] a_crcp, a_srcy, a_crsp, a_srsy, a_sysp, a_sycp;
  logic signed [31:0] a_sp, a_cp, a_cy;
  logic signed [DIFF_W-1:0] a_d0, a_d1, a_d2;

  assign pa_crcp = cr * cp;
  assign pa_srcy = sr * cy;
  assign pa_crsp = cr * sp;
  assign pa_srsy = sr * sy;
  assign pa_sysp = sy * sp;
  assign pa_sycp = sy * cp;

  always_ff @(posedge clk) begin
    if (en) begin
      a_crcp <= pa_crcp[62:30];
      a_srcy <= pa_srcy[62:30];
      a_crsp <= pa_crsp[62:30];
      a_srsy <= pa_srsy[62:30];
      a_sysp <= pa_sysp[62:30];
      a_sycp <= pa_sycp[62:30];
      a_sp   <= sp;
      a_cp   <= cp;
      a_cy   <= cy;
      a_d0   <= d0;
      a_d1   <= d1;
      a_d2   <= d2;
    end
  end

  // stage B
  logic signed [64:0] pb_t1, pb_t2;
  logic signed [32:0] b_t1, b_t2, b_crcp, b_crsp, b_srsy, b_sysp, b_sycp;
  logic signed [31:0] b_cy;
  logic signed [DIFF_W-1:0] b_d0, b_d1, b_d2;

  assign pb_t1 = a_srcy * a_sp;
  assign pb_t2 = a_srcy * a_cp;

  always_ff @(posedge clk) begin
    if (en) begin
      b_t1   <= pb_t1[62:30];
      b_t2   <= pb_t2[62:30];
      b_crcp <= a_crcp;
      b_crsp <= a_crsp;
      b_srsy <= a_srsy;
      b_sysp <= a_sysp;
      b_sycp <= a_sycp;
      b_cy   <= a_cy;
      b_d0   <= a_d0;
      b_d1   <= a_d1;
      b_d2   <= a_d2;
    end
  end

  // stage C
  logic signed [31:0] m00, m01, m02, m20, m21, m22;
  logic signed [DIFF_W-1:0] c_d0, c_d1, c_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      m00  <= clamp30(35'(b_crcp) - 35'(b_t1));
      m01  <= clamp30(-35'(b_crsp) - 35'(b_t2));
      m02  <= clamp30(35'(b_srsy));
      m20  <= clamp30(35'(b_sysp));
      m21  <= clamp30(35'(b_sycp));
      m22  <= clamp30(35'(b_cy));
      c_d0 <= b_d0;
      c_d1 <= b_d1;
      c_d2 <= b_d2;
    end
  end

  // stage D
  logic signed [64:0] p00, p01, p02, p20, p21, p22;
  logic signed [34:0] e00, e01, e02, e20, e21, e22;

  assign p00 = m00 * c_d0;
  assign p01 = m01 * c_d1;
  assign p02 = m02 * c_d2;
  assign p20 = m20 * c_d0;
  assign p21 = m21 * c_d1;
  assign p22 = m22 * c_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      e00 <= p00[64:30];
      e01 <= p01[64:30];
      e02 <= p02[64:30];
      e20 <= p20[64:30];
      e21 <= p21[64:30];
      e22 <= p22[64:30];
    end
  end

  // stage E
  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= ROT_W'(e00) + ROT_W'(e01) + ROT_W'(e02);
      r2 <= ROT_W'(e20) + ROT_W'(e21) + ROT_W'(e22);
    end
  end

endmodule

// ===== hdl/ghrc_atan.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) rounded to 16-bit binary angle units.
// Depends on ghrc_pkg for the arctangent table and widths.
module ghrc_atan import ghrc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ROT_W-1:0] x,
  input  logic signed [ROT_W-1:0] y,
  output logic [15:0]             ang
);

  localparam int W = 60;

  logic signed [W-1:0] xs [0:CORDIC_STEPS];
  logic signed [W-1:0] ys [0:CORDIC_STEPS];
  logic [31:0]         zs [0:CORDIC_STEPS];
  logic                zf [0:CORDIC_STEPS];

  logic signed [W-1:0] xe;
  logic signed [W-1:0] ye;
  logic [31:0]         zr;

  assign xe = {{(W-ROT_W-20){x[ROT_W-1]}}, x, 20'h00000};
  assign ye = {{(W-ROT_W-20){y[ROT_W-1]}}, y, 20'h00000};

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x[ROT_W-1]) begin
        xs[0] <= -xe;
        ys[0] <= -ye;
        zs[0] <= 32'h80000000;
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= 32'h00000000;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end
      end
    end
  end

  assign zr = zs[CORDIC_STEPS] + 32'h00008000;

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= zf[CORDIC_STEPS] ? 16'h0000 : zr[31:16];
    end
  end

endmodule

// ===== hdl/ghrc_sqrt.sv =====
// Pipelined y-z distance: squares, sum, then one root bit per stage.
// Depends on ghrc_pkg for widths.
module ghrc_sqrt import ghrc_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DIFF_W-1:0] dy,
  input  logic signed [DIFF_W-1:0] dz,
  output logic [DIST_W-1:0]        root
);

  localparam int SW = 2 * DIST_W;
  localparam int RW = DIST_W + 3;

  logic [DIFF_W-1:0] ay, az;
  logic [SW-1:0]     sq_y, sq_z;
  logic [SW-1:0]     sum0;

  logic [SW-1:0]     ss [0:DIST_W];
  logic [RW-1:0]     rr [0:DIST_W];
  logic [DIST_W-1:0] qq [0:DIST_W];

  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_y <= ay * ay;
      sq_z <= az * az;
    end
  end

  assign sum0 = sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (en) begin
      ss[0] <= sum0;
      rr[0] <= '0;
      qq[0] <= '0;
    end
  end

  for (genvar i = 0; i < DIST_W; i++) begin : g_digit
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    assign rsh   = {rr[i][RW-3:0], ss[i][SW-1 -: 2]};
    assign trial = {1'b0, qq[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i+1] <= {ss[i][SW-3:0], 2'b00};
        if (rsh >= trial) begin
          rr[i+1] <= rsh - trial;
          qq[i+1] <= {qq[i][DIST_W-2:0], 1'b1};
        end else begin
          rr[i+1] <= rsh;
          qq[i+1] <= {qq[i][DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = qq[DIST_W];

endmodule

// ===== tb/sv/goal_heading_and_reach_check_top_tb.sv =====
// Testbench for goal_heading_and_reach_check_top: directed table then random pose samples,
// each result checked against an in-bench CORDIC/rotation/root predictor. Depends on ghrc_pkg.
`timescale 1ns / 1ps
module goal_heading_and_reach_check_top_tb;
  import ghrc_pkg::*;

  localparam int N_RANDOM = 1530;
  localparam int TAIL_CYCLES = 200;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint GAIN = 64'sd652032874;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  logic [15:0] roll_ofs, pitch_ofs, yaw_ofs;
  logic [31:0] radius;
  out_item_t   pending_q[$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          ready_hold = 0;
  bit          calm = 1'b0;
  bit          sink_on = 1'b0;

  goal_heading_and_reach_check_top dut (.*);

  always #4 clk = ~clk;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clamp30(longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  task automatic sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] z32;
    bit          flip;
    longint      x, y, z, dx, dy;
    z32 = {ang, 16'h0};
    flip = 1'b0;
    x = GAIN;
    y = 0;
    if (z32 > 32'h40000000 && z32 < 32'hC0000000) begin
      z32 = z32 + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(z32));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(i));
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic logic [15:0] heading_of(longint xr, longint yr);
    longint      x, y, dx, dy;
    logic [31:0] z;
    x = xr * 1048576;
    y = yr * 1048576;
    z = 0;
    if (x == 0 && y == 0) return 16'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic logic [32:0] yz_length(longint dy, longint dz);
    logic [67:0] t, res, b;
    t = dy * dy + dz * dz;
    res = 0;
    b = 68'h1 << 66;
    while (b > t) b >>= 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    if (res > 68'h1FFFFFFFF) res = 68'h1FFFFFFFF;
    return res[32:0];
  endfunction

  task automatic predict_pose(input in_item_t s, output out_item_t r);
    longint d0, d1, d2, sr, cr, sp, cp, sy, cy;
    longint m00, m01, m02, m20, m21, m22, r0, r2;
    logic [32:0] dist_e;
    d0 = longint'(s.goal_x) - longint'(s.pos_x);
    d1 = longint'(s.goal_y) - longint'(s.pos_y);
    d2 = longint'(s.goal_z) - longint'(s.pos_z);
    sin_cos(s.imu_roll + roll_ofs, sr, cr);
    sin_cos(s.imu_pitch + pitch_ofs, sp, cp);
    sin_cos(s.imu_yaw + yaw_ofs, sy, cy);
    m00 = clamp30(mul30(cr, cp) - mul30(mul30(sr, cy), sp));
    m01 = clamp30(-mul30(cr, sp) - mul30(mul30(sr, cy), cp));
    m02 = clamp30(mul30(sr, sy));
    m20 = clamp30(mul30(sy, sp));
    m21 = clamp30(mul30(sy, cp));
    m22 = clamp30(cy);
    r0 = asr(m00 * d0, 30) + asr(m01 * d1, 30) + asr(m02 * d2, 30);
    r2 = asr(m20 * d0, 30) + asr(m21 * d1, 30) + asr(m22 * d2, 30);
    dist_e = yz_length(d1, d2);
    r.reached = ({1'b0, radius} > dist_e);
    r.heading_angle = heading_of(r0, -r2);
    r.goal_distance = dist_e;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROLL:   roll_ofs = v[15:0];
      CFG_PITCH:  pitch_ofs = v[15:0];
      CFG_YAW:    yaw_ofs = v[15:0];
      CFG_RADIUS: radius = v;
      default:    radius = radius;
    endcase
  endtask

  task automatic drain_all();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_pose(input in_item_t s);
    out_item_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pose(s, r);
    pending_q.push_back(r);
    n_sent++;
  endtask

  task automatic send_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic in_item_t rand_pose();
    in_item_t s;
    int m;
    m = $urandom_range(0, 3);
    s.goal_x = rand_coord(m);
    s.goal_y = rand_coord(m);
    s.goal_z = rand_coord(m);
    s.pos_x = (m == 1) ? s.goal_x + rand_coord(1) : rand_coord(m);
    s.pos_y = (m == 1) ? s.goal_y + (rand_coord(1) >>> 2) : rand_coord(m);
    s.pos_z = (m == 1) ? s.goal_z + (rand_coord(1) >>> 2) : rand_coord(m);
    s.imu_roll = $urandom();
    s.imu_pitch = $urandom();
    s.imu_yaw = $urandom();
    return s;
  endfunction

  // directed rows: goal x/y/z, pos x/y/z, roll/pitch/yaw, typed result where obvious
  typedef struct {
    in_item_t  s;
    bit        typed;
    out_item_t r;
  } pose_row_t;

  function automatic pose_row_t mk(logic signed [31:0] gx, gy, gz, px, py, pz,
                                   logic signed [15:0] ro, pi, ya,
                                   bit typed, out_item_t r);
    pose_row_t row;
    row.s = '{gx, gy, gz, px, py, pz, ro, pi, ya};
    row.typed = typed;
    row.r = r;
    return row;
  endfunction

  pose_row_t dir_rows[$];
  localparam logic signed [31:0] MX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MN = -32'sh80000000;

  initial begin
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 16'sh0, 33'h0}));
    dir_rows.push_back(mk(32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 16'sh0, 33'h0}));
    dir_rows.push_back(mk(-32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          '{1'b1, -16'sh8000, 33'h0}));
    dir_rows.push_back(mk(0, 32'sh4000, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(0, 32'sh3FFF, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(0, 0, 32'sh30000, 0, 0, 32'sh10000, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(MX, MX, MX, MN, MN, MN, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(MN, MN, MN, MX, MX, MX, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(MX, 0, MN, MN, MN, MX, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 0, '0));
    dir_rows.push_back(mk(MN, MX, MX, MX, MN, 0, -16'sh8000, 16'sh7FFF, -16'sh8000, 0, '0));
    dir_rows.push_back(mk(32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0,
                          16'sh4000, 16'sh4000, 16'sh4000, 0, '0));
    dir_rows.push_back(mk(32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0,
                          -16'sh4000, 16'sh2000, -16'sh2000, 0, '0));
    dir_rows.push_back(mk(-32'sh10000, 5, -7, 3, 0, 0, 16'sh4001, 16'shBFFF, 16'sh0, 0, '0));
    dir_rows.push_back(mk(1, -1, 1, 0, 0, 0, 16'sh1234, -16'sh1234, 16'sh0800, 0, '0));
    dir_rows.push_back(mk(-1, 1, -1, 0, 0, 0, 16'sh0, 16'sh0, -16'sh4000, 0, '0));
    dir_rows.push_back(mk(0, 0, 32'sh10000, 0, 0, 0, 16'sh0, 16'sh4000, 16'sh4000, 0, '0));
  end

  task automatic run_directed();
    out_item_t r;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].typed) begin
        predict_pose(dir_rows[k].s, r);
        if (r !== dir_rows[k].r)
          $display("%0t directed row %0d: expected %p, predictor %p", $time, k,
                   dir_rows[k].r, r);
        if (r !== dir_rows[k].r) n_err++;
      end
      send_pose(dir_rows[k].s);
    end
    send_idle();
  endtask

  always @(posedge clk) begin
    if (!rst && sink_on) begin
      if (out_valid && out_ready) begin
        n_got++;
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data);
          n_err++;
        end else begin
          out_item_t e;
          e = pending_q.pop_front();
          if (out_data.reached !== e.reached) begin
            $display("%0t reached: expected %0b actual %0b", $time, e.reached,
                     out_data.reached);
            n_err++;
          end
          if (out_data.heading_angle !== e.heading_angle) begin
            $display("%0t heading_angle: expected %0d actual %0d", $time,
                     e.heading_angle, out_data.heading_angle);
            n_err++;
          end
          if (out_data.goal_distance !== e.goal_distance) begin
            $display("%0t goal_distance: expected %0h actual %0h", $time,
                     e.goal_distance, out_data.goal_distance);
            n_err++;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #50ms;
    $display("goal_heading_and_reach_check_top_tb: done, errors");
    $finish;
  end

  initial begin
    roll_ofs = 0;
    pitch_ofs = 0;
    yaw_ofs = 0;
    radius = RADIUS_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sink_on = 1'b1;
    @(posedge clk);
    run_directed();
    drain_all();

    write_reg(CFG_ROLL, 32'h0000_7FFF);
    write_reg(CFG_PITCH, 32'hFFFF_8000);
    write_reg(CFG_YAW, 32'h0000_4000);
    write_reg(CFG_RADIUS, 32'hFFFF_FFFF);
    for (int i = 0; i < 200; i++) send_pose(rand_pose());
    send_idle();
    drain_all();

    write_reg(CFG_RADIUS, 32'h0);
    write_reg(CFG_ROLL, 32'h0000_8000);
    write_reg(CFG_PITCH, 32'h0000_7FFF);
    write_reg(CFG_YAW, 32'hFFFF_8000);
    for (int i = 0; i < 200; i++) send_pose(rand_pose());
    send_idle();
    drain_all();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_ROLL, $urandom());
      write_reg(CFG_PITCH, $urandom());
      write_reg(CFG_YAW, $urandom());
      write_reg(CFG_RADIUS, $urandom_range(0, 32'h0004_0000));
      if (ph == 4) calm = 1'b1;
      for (int i = 0; i < (N_RANDOM - 400) / 5; i++) send_pose(rand_pose());
      send_idle();
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d pose samples over 8 offset/radius settings, %0d results checked.",
             n_sent, n_got);
    if (n_err == 0 && pending_q.size() == 0)
      $display("goal_heading_and_reach_check_top_tb: done, clean");
    else
      $display("goal_heading_and_reach_check_top_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ghrc_pkg.sv
hdl/ghrc_delay.sv
hdl/ghrc_sincos.sv
hdl/ghrc_rot.sv
hdl/ghrc_atan.sv
hdl/ghrc_sqrt.sv
hdl/goal_heading_and_reach_check_top.sv
tb/sv/goal_heading_and_reach_check_top_tb.sv
